### rtl/bm25ds_pkg.sv
package bm25ds_pkg;

    localparam int SCORE_FRAC_BITS_DEF = 16;

    localparam int MUL_W = 32;
    localparam int NUM_W = 59;
    localparam int DEN_W = 57;

    localparam logic [27:0] LN2_Q28 = 28'd186065279;

    localparam logic [1:0] CFG_K1  = 2'd0;
    localparam logic [1:0] CFG_B   = 2'd1;
    localparam logic [1:0] CFG_AVG = 2'd2;
    localparam logic [1:0] CFG_N   = 2'd3;

endpackage

### rtl/bm25ds_mul.sv
module bm25ds_mul (
    input  logic [bm25ds_pkg::MUL_W-1:0]   op_a,
    input  logic [bm25ds_pkg::MUL_W-1:0]   op_b,
    output logic [2*bm25ds_pkg::MUL_W-1:0] prod
);
    import bm25ds_pkg::*;

    assign prod = {{MUL_W{1'b0}}, op_a} * {{MUL_W{1'b0}}, op_b};

endmodule

### rtl/bm25ds_div.sv
// restoring divider: floor(num * 2^F / den), quotient known below 8 * 2^F
module bm25ds_div #(
    parameter int FRAC_BITS = bm25ds_pkg::SCORE_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bm25ds_pkg::NUM_W-1:0]   num,
    input  logic [bm25ds_pkg::DEN_W-1:0]   den,
    output logic                           busy,
    output logic [FRAC_BITS+2:0]           quo
);
    import bm25ds_pkg::*;

    localparam int QW = FRAC_BITS + 3;
    localparam int CNT_W = $clog2(QW);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dv_reg, dv_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [NUM_W-1:0] cur;
    logic             int_phase;

    always_comb
    begin
        int_phase = (cnt_reg < CNT_W'(3));
        cur       = int_phase ? rem_reg : {rem_reg[NUM_W-2:0], 1'b0};
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = num;
            dv_next   = {den, 2'b00};
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cur >= dv_reg)
            begin
                rem_next = cur - dv_reg;
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = cur;
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            // integer bits walk the divisor down to den
            if (cnt_reg < CNT_W'(2))
            begin
                dv_next = {1'b0, dv_reg[NUM_W-1:1]};
            end
            if (cnt_reg == CNT_W'(QW - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

### rtl/bm25_document_score.sv
// BM25 document scorer.
// Input channel: one query term per word (term_freq, doc_freq, doc_len, last_term),
// taken when in_valid is high and in_stall low. in_stall is high while a term is in work.
// Output channel: doc_score is offered with out_valid once per document, after the
// term flagged last_term; it holds until out_stall is low at a clock edge.
// Config: cfg_we writes cfg_data into register cfg_index (k1, b, avgdl, N).
// Work per term: a term with term_freq zero goes straight to the final step. Any other
// term runs 7 multiplies for the length-normalized weight, two base-2 logarithms (each
// one setup step, then 30 mantissa squarings on the shared 32x32 multiplier), 2 multiplies
// for ln 2 scaling, a wait for the quotient, one multiply-accumulate step and one step to
// post the score. The weight division runs on its own restoring divider under the
// logarithm steps.
// The result word sits in an output register, so the next term is taken while it
// waits; a last term stays in its final cycle only while the earlier score is unread.
// Reset clears the running sum, the output valid and restores default config.
module bm25_document_score #(
    parameter int SCORE_FRAC_BITS = bm25ds_pkg::SCORE_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] term_freq,
    input  logic [15:0] doc_freq,
    input  logic [15:0] doc_len,
    input  logic        last_term,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] doc_score
);
    import bm25ds_pkg::*;

    localparam int FW     = SCORE_FRAC_BITS;
    localparam int WW     = FW + 3;
    localparam int IW     = FW + 4;
    localparam int IDF_SH = 58 - FW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_LINIT = 4'd2;
    localparam logic [3:0] S_LITER = 4'd3;
    localparam logic [3:0] S_IDF   = 4'd4;
    localparam logic [3:0] S_WDIV  = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic [2:0]  step_reg, step_next;

    logic [9:0]  k1_reg;
    logic [8:0]  b_reg;
    logic [23:0] avg_reg;
    logic [15:0] ndocs_reg;

    logic [31:0] sum_reg, sum_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] score_reg, score_next;

    logic [15:0] tf_reg, df_reg, len_reg;
    logic        last_reg;

    logic [26:0]      t1_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;

    logic        lsel_reg;
    logic [4:0]  e_reg;
    logic [30:0] m_reg;
    logic [29:0] frac_reg;
    logic [4:0]  it_reg;
    logic [34:0] lhi_reg;
    logic [34:0] d_reg;
    logic [45:0] hi_reg;
    logic [IW-1:0] idf_reg;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] prod;

    logic          div_start, div_busy;
    logic [WW-1:0] div_quo;

    logic        in_acc;
    logic [23:0] a_eff;
    logic [8:0]  bb;
    logic [17:0] lv;
    logic [4:0]  lv_msb;
    logic [31:0] sq;
    logic [34:0] lres;
    logic [62:0] ln_total;
    logic [32:0] acc_sum;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign a_eff     = (avg_reg == 24'd0) ? 24'd1 : avg_reg;
    assign bb        = (b_reg > 9'd256) ? 9'd256 : b_reg;
    assign div_start = (state_reg == S_LINIT) && !lsel_reg;

    bm25ds_mul u_mul (
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    bm25ds_div #(
        .FRAC_BITS (FW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = MUL_W'(tf_reg);
                        mul_b = MUL_W'({1'b0, k1_reg} + 11'd256);
                    end
                    3'd1:
                    begin
                        mul_a = MUL_W'(t1_reg);
                        mul_b = MUL_W'(a_eff);
                    end
                    3'd2:
                    begin
                        mul_a = MUL_W'(tf_reg);
                        mul_b = MUL_W'(a_eff);
                    end
                    3'd3:
                    begin
                        mul_a = MUL_W'(k1_reg);
                        mul_b = MUL_W'(9'd256 - bb);
                    end
                    3'd4:
                    begin
                        mul_a = MUL_W'(t1_reg);
                        mul_b = MUL_W'(a_eff);
                    end
                    3'd5:
                    begin
                        mul_a = MUL_W'(k1_reg);
                        mul_b = MUL_W'(bb);
                    end
                    3'd6:
                    begin
                        mul_a = MUL_W'(t1_reg);
                        mul_b = MUL_W'(len_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_LITER:
            begin
                mul_a = MUL_W'(m_reg);
                mul_b = MUL_W'(m_reg);
            end
            S_IDF:
            begin
                mul_a = (step_reg == 3'd0) ? MUL_W'(d_reg[34:17]) : MUL_W'(d_reg[16:0]);
                mul_b = MUL_W'(LN2_Q28);
            end
            S_ACC:
            begin
                mul_a = MUL_W'(idf_reg);
                mul_b = MUL_W'(div_quo);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // log2 operand and its leading one
    always_comb
    begin
        lv = lsel_reg ? {1'b0, df_reg, 1'b1} : ({1'b0, ndocs_reg, 1'b0} + 18'd2);
        lv_msb = 5'd0;
        for (int i = 0; i < 18; i++)
        begin
            if (lv[i])
            begin
                lv_msb = 5'(i);
            end
        end
    end

    assign sq       = prod[61:30];
    assign lres     = {e_reg, frac_reg | (sq[31] ? (30'd1 << it_reg) : 30'd0)};
    assign ln_total = {hi_reg, 17'd0} + 63'(prod[44:0]);
    assign acc_sum  = {1'b0, sum_reg} + 33'(prod[2*FW+6:FW]);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        score_next     = score_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    step_next  = 3'd0;
                    state_next = (term_freq == 16'd0) ? S_FIN : S_MUL;
                end
            end
            S_MUL:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6)
                begin
                    state_next = S_LINIT;
                end
            end
            S_LINIT:
            begin
                state_next = S_LITER;
            end
            S_LITER:
            begin
                if (it_reg == 5'd0)
                begin
                    step_next  = 3'd0;
                    state_next = lsel_reg ? S_IDF : S_LINIT;
                end
            end
            S_IDF:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd1)
                begin
                    state_next = S_WDIV;
                end
            end
            S_WDIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                sum_next   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    score_next     = sum_reg;
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 3'd0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            k1_reg        <= 10'd384;
            b_reg         <= 9'd192;
            avg_reg       <= 24'd2560;
            ndocs_reg     <= 16'd1;
            lsel_reg      <= 1'b0;
            it_reg        <= 5'd0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_K1:  k1_reg    <= cfg_data[9:0];
                    CFG_B:   b_reg     <= cfg_data[8:0];
                    CFG_AVG: avg_reg   <= cfg_data;
                    CFG_N:   ndocs_reg <= cfg_data[15:0];
                    default: k1_reg    <= k1_reg;
                endcase
            end
            if (state_reg == S_IDLE)
            begin
                lsel_reg <= 1'b0;
            end
            else if (state_reg == S_LINIT)
            begin
                it_reg <= 5'd29;
            end
            else if (state_reg == S_LITER)
            begin
                if (it_reg == 5'd0)
                begin
                    lsel_reg <= 1'b1;
                end
                else
                begin
                    it_reg <= it_reg - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        if (in_acc)
        begin
            tf_reg   <= term_freq;
            df_reg   <= (doc_freq > ndocs_reg) ? ndocs_reg : doc_freq;
            len_reg  <= doc_len;
            last_reg <= last_term;
        end
        if (state_reg == S_MUL)
        begin
            case (step_reg)
                3'd1:    num_reg <= {prod[50:0], 8'd0};
                3'd2:    den_reg <= {1'b0, prod[39:0], 16'd0};
                3'd4:    den_reg <= den_reg + DEN_W'(prod[42:0]);
                3'd6:    den_reg <= den_reg + DEN_W'({prod[34:0], 8'd0});
                default: t1_reg  <= prod[26:0];
            endcase
        end
        if (state_reg == S_LINIT)
        begin
            e_reg    <= lv_msb;
            m_reg    <= 31'({13'd0, lv} << (5'd30 - lv_msb));
            frac_reg <= '0;
        end
        if (state_reg == S_LITER)
        begin
            m_reg    <= sq[31] ? sq[31:1] : sq[30:0];
            frac_reg <= lres[29:0];
            if (it_reg == 5'd0)
            begin
                if (!lsel_reg)
                begin
                    lhi_reg <= lres;
                end
                else
                begin
                    d_reg <= (lhi_reg > lres) ? (lhi_reg - lres) : 35'd0;
                end
            end
        end
        if (state_reg == S_IDF)
        begin
            if (step_reg == 3'd0)
            begin
                hi_reg <= prod[45:0];
            end
            else
            begin
                idf_reg <= IW'(ln_total >> IDF_SH);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign doc_score = score_reg;

endmodule

### test/tb_bm25_document_score.sv
module tb_bm25_document_score;
    timeunit 1ns;
    timeprecision 1ps;

    import bm25ds_pkg::*;

    localparam int FRAC = 16;
    localparam int QUIET_LIMIT = 6000;
    localparam logic [63:0] LN2_CONST = 64'd186065279;

    class bm25_scoreboard;
        logic [9:0]  k1;
        logic [8:0]  b;
        logic [23:0] avgdl;
        logic [15:0] ndocs;
        logic [31:0] run_sum;
        logic [31:0] score_q[$];
        int          errors;

        function new();
            k1 = 10'd384;
            b = 9'd192;
            avgdl = 24'd2560;
            ndocs = 16'd1;
            run_sum = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] val);
            case (idx)
                CFG_K1:  k1 = val[9:0];
                CFG_B:   b = val[8:0];
                CFG_AVG: avgdl = val;
                CFG_N:   ndocs = val[15:0];
                default: ;
            endcase
        endfunction

        // base-2 log in Q30 by mantissa squaring, truncated
        function logic [63:0] log2_q30(logic [31:0] v);
            int unsigned e;
            logic [63:0] m;
            logic [63:0] fr;
            fr = '0;
            e = 0;
            if (v == 0) v = 1;
            while (e < 31 && (v >> (e + 1)) != 0) e++;
            m = 64'(v) << (30 - e);
            for (int i = 29; i >= 0; i--)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31))
                begin
                    m = m >> 1;
                    fr[i] = 1'b1;
                end
            end
            return (64'(e) << 30) | fr;
        endfunction

        function logic [63:0] weight_div(logic [63:0] num, logic [63:0] den);
            logic [63:0] q;
            logic [63:0] r;
            q = num / den;
            r = num % den;
            for (int i = 0; i < FRAC; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        function void note_term(logic [15:0] tf, logic [15:0] df, logic [15:0] len,
                                logic last);
            logic [63:0] kk, bb, aa, lhi, llo, d, idf, num, den, w, s;
            if (tf != 0)
            begin
                kk = 64'(k1);
                bb = (b > 9'd256) ? 64'd256 : 64'(b);
                aa = (avgdl == 0) ? 64'd1 : 64'(avgdl);
                if (df > ndocs) df = ndocs;
                lhi = log2_q30(32'(2 * 64'(ndocs) + 2));
                llo = log2_q30(32'(2 * 64'(df) + 1));
                d = (lhi > llo) ? lhi - llo : 64'd0;
                idf = (d * LN2_CONST) >> (58 - FRAC);
                num = 64'(tf) * (kk + 256) * 256 * aa;
                den = 64'(tf) * 65536 * aa + kk * ((256 - bb) * aa + 256 * bb * 64'(len));
                w = weight_div(num, den);
                s = 64'(run_sum) + ((idf * w) >> FRAC);
                run_sum = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
            end
            if (last)
            begin
                score_q = {score_q, run_sum};
                run_sum = '0;
            end
        endfunction

        function void check_score(logic [31:0] got);
            logic [31:0] want;
            if (score_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected score word %h", got);
                return;
            end
            want = score_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10) $display("doc_score mismatch: expected %h, got %h", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] term_freq = '0;
    logic [15:0] doc_freq = '0;
    logic [15:0] doc_len = '0;
    logic        last_term = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] doc_score;

    bm25_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    bm25_document_score u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .term_freq(term_freq), .doc_freq(doc_freq), .doc_len(doc_len),
        .last_term(last_term),
        .out_valid(out_valid), .out_stall(out_stall), .doc_score(doc_score)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_term(term_freq, doc_freq, doc_len, last_term);
        if (rst_n && out_valid && !out_stall)
            sb.check_score(doc_score);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_term(logic [15:0] tf, logic [15:0] df, logic [15:0] len, logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        term_freq <= tf;
        doc_freq <= df;
        doc_len <= len;
        last_term <= last;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.score_q.size() != 0) @(posedge clk);
        // a term with no score may still be in flight
        repeat (100) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic set_config(logic [9:0] k, logic [8:0] bw, logic [23:0] a, logic [15:0] n);
        write_reg(CFG_K1, 24'(k));
        write_reg(CFG_B, 24'(bw));
        write_reg(CFG_AVG, a);
        write_reg(CFG_N, 24'(n));
    endtask

    task automatic random_terms(int count);
        logic [15:0] tf, df, len;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: tf = '0;
                1: tf = 16'($urandom_range(1, 8));
                default: tf = 16'($urandom);
            endcase
            df = $urandom_range(0, 1) ? 16'($urandom_range(0, int'(sb.ndocs) + 2)) : 16'($urandom);
            len = $urandom_range(0, 1) ? 16'($urandom_range(0, 40)) : 16'($urandom);
            send_term(tf, df, len, $urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults: field extremes, absent terms, df clamp
        send_term(16'd0, 16'd0, 16'd0, 1'b1);
        send_term(16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_term(16'd1, 16'hFFFF, 16'hFFFF, 1'b1);
        send_term(16'd3, 16'd1, 16'd10, 1'b0);
        send_term(16'd0, 16'd5, 16'd7, 1'b1);
        drain();

        set_config(10'd1023, 9'd256, 24'hFFFFFF, 16'hFFFF);
        send_term(16'd1, 16'd0, 16'hFFFF, 1'b1);
        send_term(16'hFFFF, 16'hFFFF, 16'd0, 1'b1);
        send_term(16'd5, 16'd20, 16'd100, 1'b1);
        random_terms(80);
        drain();

        // b above one, zero average length, zero corpus size
        set_config(10'd0, 9'd511, 24'd0, 16'd0);
        send_term(16'd2, 16'd3, 16'd4, 1'b1);
        drain();
        write_reg(CFG_K1, 24'd700);
        send_term(16'd2, 16'd0, 16'd4, 1'b1);
        idle_pct = 73;
        random_terms(80);
        drain();

        set_config(10'd384, 9'd0, 24'd1, 16'd1000);
        idle_pct = 0;
        stall_pct = 73;
        random_terms(80);
        drain();

        set_config(10'd200, 9'd128, 24'd5000, 16'd50);
        idle_pct = 15;
        stall_pct = 15;
        random_terms(80);
        drain();

        // long document to push the sum into saturation
        set_config(10'd1023, 9'd0, 24'd256, 16'hFFFF);
        idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 1200; i++)
            send_term(16'hFFFF, 16'd0, 16'd1, 1'b0);
        send_term(16'd0, 16'd0, 16'd0, 1'b1);
        drain();

        set_config(10'($urandom), 9'($urandom_range(0, 256)), 24'($urandom_range(1, 8000)),
                   16'($urandom_range(1, 65535)));
        random_terms(80);

        in_valid <= 1'b0;
        while (sb.score_q.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
